// ----- rtl/sar_pkg.sv -----
// Package for the swap annuity and rate block: formats, codes, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package sar_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int BOND_FRAC   = 30;
    localparam int WORD_W      = 32;
    localparam int START_W     = 6;
    localparam int END_W       = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int SUM_W       = 40;
    localparam int PROD_W      = 65;
    localparam int DEN_W       = 64;
    localparam int TERM_W      = 34;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int MAX_FORWARDS_DEFAULT = 64;

    localparam logic [WORD_W-1:0] BOND_ONE = WORD_W'(1) << BOND_FRAC;
    localparam logic [WORD_W-1:0] RATE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] RATE_NEG_MAX = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 1'b1;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_BAD_DEN      = 2'd2;
    localparam logic [1:0] STATUS_BAD_ANNUITY  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DSTART,
        ST_DIV,
        ST_TERM,
        ST_SUM,
        ST_POS,
        ST_FIN,
        ST_RSTART,
        ST_RDIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic check;
        logic bond_div_start;
        logic term;
        logic sum;
        logic pos;
        logic fin;
        logic rate_div_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic den_bad;
        logic den_err;
        logic div_done;
        logic is_last;
        logic code_ok;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/sar_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit saturated
// quotient of {hi, lo} / divisor. Depends on sar_pkg.
`default_nettype none

module sar_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [sar_pkg::DEN_W-1:0]      hi,
    input  wire logic [sar_pkg::WORD_W-1:0]     lo,
    input  wire logic [sar_pkg::DEN_W-1:0]      divisor,
    output logic                                done,
    output logic [sar_pkg::WORD_W-1:0]          quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              sat_reg;
    logic [sar_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [sar_pkg::DEN_W-1:0]         rem_reg;
    logic [sar_pkg::DEN_W-1:0]         d_reg;
    logic [sar_pkg::WORD_W-1:0]        lo_reg;
    logic [sar_pkg::WORD_W-1:0]        quo_reg;

    logic [sar_pkg::DEN_W:0]           trial;
    logic [sar_pkg::DEN_W:0]           diff;
    logic                              take;
    logic [sar_pkg::DEN_W-1:0]         rem_next;

    always_comb begin
        trial    = {rem_reg, lo_reg[sar_pkg::WORD_W-1]};
        diff     = trial - {1'b0, d_reg};
        take     = trial >= {1'b0, d_reg};
        rem_next = take ? diff[sar_pkg::DEN_W-1:0] : trial[sar_pkg::DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (hi >= divisor) begin
                    // quotient reaches 2^32: saturate
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    sat_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= sar_pkg::DIV_CNT_W'(sar_pkg::DIV_STEPS);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == sar_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi;
            lo_reg  <= lo;
            d_reg   <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[sar_pkg::WORD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[sar_pkg::WORD_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : quo_reg;

endmodule

`default_nettype wire

// ----- rtl/sar_datapath.sv -----
// Datapath: configuration registers, curve state, multipliers, accumulator,
// shared divider and result register. Depends on sar_pkg and sar_div.
`default_nettype none

module sar_datapath #(
    parameter int MAX_FORWARDS = sar_pkg::MAX_FORWARDS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sar_pkg::cmd_t                      cmd,
    output sar_pkg::sts_t                           sts,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sar_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic signed [sar_pkg::WORD_W-1:0]  s_forward_rate,
    input  wire logic [sar_pkg::WORD_W-1:0]         s_accrual,
    input  wire logic                               s_is_last,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [sar_pkg::WORD_W-1:0]              m_annuity,
    output logic signed [sar_pkg::WORD_W-1:0]       m_swap_rate,
    output logic [1:0]                              m_status
);

    localparam int PW = $clog2(MAX_FORWARDS + 2);
    localparam int CW = (PW > sar_pkg::END_W) ? PW : sar_pkg::END_W;
    localparam logic signed [sar_pkg::PROD_W-1:0] ONE2 =
        sar_pkg::PROD_W'(1) << (2 * sar_pkg::FRAC_BITS);
    localparam logic signed [sar_pkg::PROD_W-1:0] NEG_ONE2 = -ONE2;
    localparam int RATE_SHIFT = 2 * sar_pkg::FRAC_BITS - sar_pkg::BOND_FRAC;
    localparam int BOND_SHIFT = 2 * sar_pkg::FRAC_BITS - sar_pkg::WORD_W;
    localparam int MAG_W = sar_pkg::DEN_W + sar_pkg::WORD_W;

    // configuration
    logic [sar_pkg::START_W-1:0]        start_index_reg;
    logic [sar_pkg::END_W-1:0]          end_index_reg;

    // curve state
    logic [PW-1:0]                      position_reg;
    logic [sar_pkg::WORD_W-1:0]         bond_reg;
    logic [sar_pkg::SUM_W-1:0]          sum_reg;
    logic [sar_pkg::WORD_W-1:0]         end_bond_reg;
    logic                               den_err_reg;

    // item registers
    logic signed [sar_pkg::WORD_W-1:0]  fw_reg;
    logic [sar_pkg::WORD_W-1:0]         acc_reg;
    logic                               last_reg;
    logic                               active_reg;
    logic                               in_ann_reg;
    logic                               at_end_reg;
    logic signed [sar_pkg::PROD_W-1:0]  prod_reg;
    logic [sar_pkg::DEN_W-1:0]          den_reg;
    logic [sar_pkg::TERM_W-1:0]         term_reg;
    logic [1:0]                         status_reg;
    logic                               neg_reg;
    logic [sar_pkg::DEN_W-1:0]          mag_hi_reg;
    logic [sar_pkg::WORD_W-1:0]         mag_lo_reg;

    // result register
    logic                               m_valid_reg;
    logic [sar_pkg::WORD_W-1:0]         m_annuity_reg;
    logic [sar_pkg::WORD_W-1:0]         m_swap_rate_reg;
    logic [1:0]                         m_status_reg;

    logic [CW-1:0]                      pos_x;
    logic [CW-1:0]                      start_x;
    logic [CW-1:0]                      end_x;
    logic [CW-1:0]                      max_x;
    logic                               active_now;
    logic [1:0]                         code;
    logic signed [sar_pkg::PROD_W-1:0]  prod_full;
    logic [2*sar_pkg::WORD_W-1:0]       term_full;
    logic [sar_pkg::SUM_W:0]            sum_add;
    logic [sar_pkg::WORD_W-1:0]         abs_num;
    logic [MAG_W-1:0]                   mag;
    logic [sar_pkg::WORD_W-1:0]         rate_out;
    logic [sar_pkg::WORD_W-1:0]         ann_out;

    logic                               div_start;
    logic [sar_pkg::DEN_W-1:0]          div_hi;
    logic [sar_pkg::WORD_W-1:0]         div_lo;
    logic [sar_pkg::DEN_W-1:0]          div_d;
    logic                               div_done;
    logic [sar_pkg::WORD_W-1:0]         div_q;

    always_comb begin
        pos_x      = CW'(position_reg);
        start_x    = CW'(start_index_reg);
        end_x      = CW'(end_index_reg);
        max_x      = CW'(MAX_FORWARDS);
        active_now = (pos_x <= max_x) && (pos_x >= start_x);

        if ((start_x >= end_x) || (end_x > pos_x) || (pos_x > max_x)) begin
            code = sar_pkg::STATUS_BAD_RANGE;
        end else if (den_err_reg) begin
            code = sar_pkg::STATUS_BAD_DEN;
        end else if (sum_reg == '0) begin
            code = sar_pkg::STATUS_BAD_ANNUITY;
        end else begin
            code = sar_pkg::STATUS_OK;
        end

        prod_full = fw_reg * $signed({1'b0, acc_reg});
        term_full = (2*sar_pkg::WORD_W)'(acc_reg) * (2*sar_pkg::WORD_W)'(div_q);
        sum_add   = (sar_pkg::SUM_W+1)'(sum_reg) + (sar_pkg::SUM_W+1)'(term_reg);

        abs_num = (end_bond_reg > sar_pkg::BOND_ONE) ? (end_bond_reg - sar_pkg::BOND_ONE)
                                                     : (sar_pkg::BOND_ONE - end_bond_reg);
        mag     = MAG_W'(abs_num) << RATE_SHIFT;

        if (neg_reg) begin
            rate_out = (div_q > sar_pkg::RATE_NEG_MAX) ? sar_pkg::RATE_NEG_MAX : (~div_q + 1'b1);
        end else begin
            rate_out = (div_q > sar_pkg::RATE_POS_MAX) ? sar_pkg::RATE_POS_MAX : div_q;
        end
        ann_out = (sum_reg > sar_pkg::SUM_W'({sar_pkg::WORD_W{1'b1}}))
                ? '1 : sum_reg[sar_pkg::WORD_W-1:0];

        div_start = cmd.bond_div_start | cmd.rate_div_start;
        div_hi    = cmd.rate_div_start ? mag_hi_reg
                                       : (sar_pkg::DEN_W'(bond_reg) << BOND_SHIFT);
        div_lo    = cmd.rate_div_start ? mag_lo_reg : '0;
        div_d     = cmd.rate_div_start ? sar_pkg::DEN_W'(sum_reg) : den_reg;
    end

    sar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .hi       (div_hi),
        .lo       (div_lo),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration and curve state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_index_reg <= '0;
            end_index_reg   <= sar_pkg::END_W'(1);
            position_reg    <= '0;
            bond_reg        <= sar_pkg::BOND_ONE;
            sum_reg         <= '0;
            end_bond_reg    <= sar_pkg::BOND_ONE;
            den_err_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    sar_pkg::CFG_START_INDEX: start_index_reg <= cfg_wdata[sar_pkg::START_W-1:0];
                    sar_pkg::CFG_END_INDEX:   end_index_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.check && active_reg && (prod_reg <= NEG_ONE2)) begin
                den_err_reg <= 1'b1;
            end
            if (cmd.term) begin
                bond_reg <= div_q;
                if (at_end_reg) begin
                    end_bond_reg <= div_q;
                end
            end
            if (cmd.sum && in_ann_reg) begin
                sum_reg <= sum_add[sar_pkg::SUM_W] ? '1 : sum_add[sar_pkg::SUM_W-1:0];
            end
            if (cmd.pos && (pos_x <= max_x)) begin
                position_reg <= position_reg + 1'b1;
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg  <= 1'b1;
                // start a fresh curve
                position_reg <= '0;
                bond_reg     <= sar_pkg::BOND_ONE;
                sum_reg      <= '0;
                end_bond_reg <= sar_pkg::BOND_ONE;
                den_err_reg  <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            fw_reg     <= s_forward_rate;
            acc_reg    <= s_accrual;
            last_reg   <= s_is_last;
            active_reg <= active_now;
            in_ann_reg <= pos_x < end_x;
            at_end_reg <= ((CW+1)'(pos_x) + 1'b1) == (CW+1)'(end_x);
        end
        if (cmd.mul) begin
            prod_reg <= prod_full;
        end
        if (cmd.check) begin
            den_reg <= prod_reg[sar_pkg::DEN_W-1:0] + ONE2[sar_pkg::DEN_W-1:0];
        end
        if (cmd.term) begin
            term_reg <= term_full[2*sar_pkg::WORD_W-1:sar_pkg::BOND_FRAC];
        end
        if (cmd.fin) begin
            status_reg <= code;
            neg_reg    <= end_bond_reg > sar_pkg::BOND_ONE;
            mag_hi_reg <= mag[MAG_W-1:sar_pkg::WORD_W];
            mag_lo_reg <= mag[sar_pkg::WORD_W-1:0];
        end
        if (cmd.emit) begin
            m_status_reg <= status_reg;
            if (status_reg == sar_pkg::STATUS_OK) begin
                m_annuity_reg   <= ann_out;
                m_swap_rate_reg <= rate_out;
            end else begin
                m_annuity_reg   <= '0;
                m_swap_rate_reg <= '0;
            end
        end
    end

    always_comb begin
        sts.active   = active_reg;
        sts.den_bad  = prod_reg <= NEG_ONE2;
        sts.den_err  = den_err_reg;
        sts.div_done = div_done;
        sts.is_last  = last_reg;
        sts.code_ok  = code == sar_pkg::STATUS_OK;
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_annuity   = m_annuity_reg;
    assign m_swap_rate = m_swap_rate_reg;
    assign m_status    = m_status_reg;

endmodule

`default_nettype wire

// ----- rtl/sar_ctrl.sv -----
// Controller state machine: sequences capture, multiply, divide, accumulate
// and result steps of the datapath. Depends on sar_pkg.
`default_nettype none

module sar_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire sar_pkg::sts_t  sts,
    output sar_pkg::cmd_t       cmd
);

    sar_pkg::state_t state_reg;
    sar_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sar_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            sar_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sar_pkg::ST_MUL;
                end
            end
            sar_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = sar_pkg::ST_CHECK;
            end
            sar_pkg::ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.active && !sts.den_bad && !sts.den_err) begin
                    state_next = sar_pkg::ST_DSTART;
                end else begin
                    state_next = sar_pkg::ST_POS;
                end
            end
            sar_pkg::ST_DSTART: begin
                cmd.bond_div_start = 1'b1;
                state_next         = sar_pkg::ST_DIV;
            end
            sar_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = sar_pkg::ST_TERM;
                end
            end
            sar_pkg::ST_TERM: begin
                cmd.term   = 1'b1;
                state_next = sar_pkg::ST_SUM;
            end
            sar_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = sar_pkg::ST_POS;
            end
            sar_pkg::ST_POS: begin
                cmd.pos    = 1'b1;
                state_next = sts.is_last ? sar_pkg::ST_FIN : sar_pkg::ST_IDLE;
            end
            sar_pkg::ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = sts.code_ok ? sar_pkg::ST_RSTART : sar_pkg::ST_EMIT;
            end
            sar_pkg::ST_RSTART: begin
                cmd.rate_div_start = 1'b1;
                state_next         = sar_pkg::ST_RDIV;
            end
            sar_pkg::ST_RDIV: begin
                if (sts.div_done) begin
                    state_next = sar_pkg::ST_EMIT;
                end
            end
            sar_pkg::ST_EMIT: begin
                // hold until the result register is free
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sar_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sar_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/swap_annuity_and_rate.sv -----
// Top level of the par swap rate and annuity block.
// Depends on sar_pkg, sar_ctrl and sar_datapath.
//
// Usage: feed one forward rate and its accrual per item on the s_ channel,
// in curve order, with s_is_last on the final forward of the curve. Only the
// item with s_is_last set produces a result on the m_ channel: annuity, par
// swap rate and status. start_index and end_index are written through
// cfg_wr_en / cfg_index / cfg_wdata while no curve is in flight.
// Throughput: one item at a time. A forward inside the bond chain runs the
// shared radix-2 divider (32 iterations plus setup) unless the bond quotient
// saturates. A forward outside the chain, or one at or after a denominator
// fault, skips the divider. The last item runs a second pass of the divider
// for the swap rate, which is skipped when the status is a fault.
// The result sits in an output register; while the receiver stalls, the
// next curve's items are still taken, and a second result waits for the
// register to drain before it is loaded.
// Reset: synchronous, active low; clears curve state, sets start_index to 0
// and end_index to 1, and empties the output register.
`default_nettype none

module swap_annuity_and_rate #(
    parameter int MAX_FORWARDS = sar_pkg::MAX_FORWARDS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sar_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [sar_pkg::WORD_W-1:0]  s_forward_rate,
    input  wire logic [sar_pkg::WORD_W-1:0]         s_accrual,
    input  wire logic                               s_is_last,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [sar_pkg::WORD_W-1:0]              m_annuity,
    output logic signed [sar_pkg::WORD_W-1:0]       m_swap_rate,
    output logic [1:0]                              m_status
);

    sar_pkg::cmd_t cmd;
    sar_pkg::sts_t sts;

    sar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sar_datapath #(
        .MAX_FORWARDS (MAX_FORWARDS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_forward_rate (s_forward_rate),
        .s_accrual      (s_accrual),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_annuity      (m_annuity),
        .m_swap_rate    (m_swap_rate),
        .m_status       (m_status)
    );

endmodule

`default_nettype wire
